@@ rtl/kepo_pkg.sv @@
// Package for the Kepler orbit oscillator: FSM states, command and status
// structs, register indexes and fixed-point constants. No dependencies.
`timescale 1ns / 1ps
package kepo_pkg;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RSQ, ST_BSQ, ST_Z, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5,
    ST_EC, ST_L, ST_T, ST_G, ST_RAD, ST_S, ST_Q, ST_DONE
  } kepo_state_t;

  typedef struct packed {
    kepo_state_t step;
    logic        go;
    logic        take_in;
    logic        emit;
  } kepo_cmd_t;

  typedef struct packed {
    logic unit_done;
    logic restart;
    logic out_free;
  } kepo_sts_t;

  localparam logic [1:0] CFG_BASE_FREQ = 2'd0;
  localparam logic [1:0] CFG_BASE_ECC  = 2'd1;
  localparam logic [1:0] CFG_FS        = 2'd2;
  localparam logic [1:0] CFG_RADIAN    = 2'd3;

  localparam logic [31:0] COS_C1     = 32'd1324675879;
  localparam logic [31:0] COS_C2     = 32'd272375560;
  localparam logic [31:0] COS_C3     = 32'd22401992;
  localparam logic [31:0] COS_C4     = 32'd987048;
  localparam logic [31:0] COS_C5     = 32'd27060;
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
  localparam logic [31:0] PI_Q24     = 32'd52707179;

endpackage

@@ rtl/kepo_mul.sv @@
// Iterative unsigned multiplier, 40 x 32 bits, 8 multiplier bits per cycle.
// Uses no package items.
`timescale 1ns / 1ps
module kepo_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [39:0] a_i,
  input  logic [31:0] b_i,
  output logic        done,
  output logic [63:0] prod
);
  logic [63:0] acc_r;
  logic [63:0] a_r;
  logic [31:0] b_r;
  logic [1:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [63:0] pp;

  assign pp = a_r * {56'd0, b_r[7:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= 2'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc_r <= 64'd0;
      a_r   <= {24'd0, a_i};
      b_r   <= b_i;
    end else if (busy_r) begin
      acc_r <= acc_r + pp;
      a_r   <= {a_r[55:0], 8'd0};
      b_r   <= {8'd0, b_r[31:8]};
    end
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

@@ rtl/kepo_div.sv @@
// Restoring divider, 64-bit dividend by 40-bit divisor, one quotient bit
// per cycle. Uses no package items.
`timescale 1ns / 1ps
module kepo_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] num_i,
  input  logic [39:0] den_i,
  output logic        done,
  output logic [63:0] quo
);
  logic [39:0] rem_r;
  logic [63:0] quo_r;
  logic [39:0] den_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [40:0] trial;
  logic        fits;

  assign trial = {rem_r, quo_r[63]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= 40'd0;
      quo_r <= num_i;
      den_r <= den_i;
    end else if (busy_r) begin
      rem_r <= fits ? 40'(trial - {1'b0, den_r}) : trial[39:0];
      quo_r <= {quo_r[62:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

@@ rtl/kepo_sqrt.sv @@
// Bit-pair integer square root of a 49-bit value, one step per cycle.
// Uses no package items.
`timescale 1ns / 1ps
module kepo_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [48:0] x_i,
  output logic        done,
  output logic [24:0] root
);
  logic [48:0] x_r;
  logic [49:0] res_r;
  logic [49:0] bit_r;
  logic        busy_r;
  logic        done_r;
  logic [49:0] trial;
  logic        fits;

  assign trial = res_r + bit_r;
  assign fits  = {1'b0, x_r} >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x_r   <= x_i;
      res_r <= 50'd0;
      bit_r <= 50'd1 << 48;
    end else if (busy_r) begin
      if (fits) begin
        x_r   <= 49'({1'b0, x_r} - trial);
        res_r <= {1'b0, res_r[49:1]} + bit_r;
      end else begin
        res_r <= {1'b0, res_r[49:1]};
      end
      bit_r <= {2'd0, bit_r[49:2]};
    end
  end

  assign done = done_r;
  assign root = res_r[24:0];
endmodule

@@ rtl/kepo_dp.sv @@
// Datapath: configuration registers, orbit state, operand selection for the
// shared multiplier, divider and square root, output register. Uses kepo_pkg.
`timescale 1ns / 1ps
module kepo_dp import kepo_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  kepo_cmd_t   cmd,
  output kepo_sts_t   sts,
  input  logic [47:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tready,
  output logic        out_tvalid,
  output logic [55:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);
  logic [31:0] bf_r;
  logic [15:0] be_r;
  logic [18:0] fs_r;
  logic        rad_r;
  logic [31:0] phase_r;
  logic [31:0] prev_r;
  logic [31:0] f_r;
  logic [15:0] e_r;
  logic [32:0] a_r;
  logic [24:0] b_r;
  logic [30:0] z_r;
  logic [31:0] p_r;
  logic [30:0] cmag_r;
  logic        cneg_r;
  logic [39:0] d7_r;
  logic [25:0] l_r;
  logic [16:0] radius_r;
  logic [41:0] t_r;
  logic [31:0] g_r;
  logic [31:0] pout_r;
  logic [63:0] prod_r;
  logic        out_valid_r;
  logic [16:0] out_radius_r;
  logic [31:0] out_phase_r;

  logic [15:0] e_sel;
  logic [32:0] a_be;
  logic [23:0] h;
  logic        fold_neg;
  logic [24:0] u;
  logic [23:0] mag;
  logic [32:0] s;
  logic        fneg;
  logic [31:0] fmag;
  logic [18:0] fs_eff;

  logic        mul_go, div_go, sq_go;
  logic [39:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] num;
  logic [39:0] dvs;
  logic [48:0] sq_x;
  logic        mul_done, div_done, sq_done;
  logic [63:0] mprod, quo;
  logic [24:0] sroot;

  logic [31:0] hk_const;
  logic [35:0] c_raw;
  logic [46:0] den;
  logic [32:0] m;
  logic [57:0] qs;
  logic [57:0] sum;
  logic [57:0] sum_abs;
  logic [31:0] frac;
  logic [31:0] phase_nxt;

  assign e_sel = in_tuser[1] ? in_tdata[47:32] : be_r;
  assign a_be  = 33'h1_0000_0000 - (33'(be_r) * 33'(be_r));

  assign h        = phase_r[23] ? 24'(25'h100_0000 - {1'b0, phase_r[23:0]}) : phase_r[23:0];
  assign fold_neg = h > 24'h40_0000;
  // middle quadrants use the distance to the half cycle
  assign u        = fold_neg ? {23'(24'h80_0000 - h), 2'b00} : {h[22:0], 2'b00};

  assign mag    = phase_r[31] ? 24'(32'd0 - phase_r) : phase_r[23:0];
  assign s      = {1'b0, g_r} + {1'b0, prev_r};
  assign fneg   = f_r[31];
  assign fmag   = fneg ? 32'd0 - f_r : f_r;
  assign fs_eff = (fs_r == 19'd0) ? 19'd1 : fs_r;

  always_comb begin
    mul_go = 1'b0;
    div_go = 1'b0;
    sq_go  = 1'b0;
    mul_a  = {15'd0, u};
    mul_b  = {7'd0, u};
    num    = {a_r, 31'd0};
    dvs    = d7_r;
    sq_x   = {a_r, 16'd0};
    case (cmd.step)
      ST_RSQ: begin
        sq_go = cmd.go;
        sq_x  = {a_be, 16'd0};
      end
      ST_BSQ: sq_go = cmd.go;
      ST_Z:   mul_go = cmd.go;
      ST_H1, ST_H2, ST_H3, ST_H4, ST_H5: begin
        mul_go = cmd.go;
        mul_a  = {8'd0, p_r};
        mul_b  = {1'b0, z_r};
      end
      ST_EC: begin
        mul_go = cmd.go;
        mul_a  = {24'd0, e_r};
        mul_b  = {1'b0, cmag_r};
      end
      ST_L: div_go = cmd.go;
      ST_T: begin
        div_go = cmd.go;
        num    = {15'd0, b_r, 24'd0};
        dvs    = {14'd0, l_r};
      end
      ST_G: begin
        div_go = cmd.go;
        num    = {6'd0, t_r, 16'd0};
        dvs    = {14'd0, l_r};
      end
      ST_RAD: begin
        mul_go = cmd.go;
        mul_a  = {16'd0, mag};
        mul_b  = TWO_PI_Q29;
      end
      ST_S: begin
        mul_go = cmd.go;
        mul_a  = {7'd0, s};
        mul_b  = fmag;
      end
      ST_Q: begin
        div_go = cmd.go;
        num    = prod_r;
        dvs    = {12'd0, fs_eff, 9'd0};
      end
      default: ;
    endcase
  end

  kepo_mul u_mul (
    .clk(clk), .rst_n(rst_n), .go(mul_go), .a_i(mul_a), .b_i(mul_b),
    .done(mul_done), .prod(mprod)
  );
  kepo_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num_i(num), .den_i(dvs),
    .done(div_done), .quo(quo)
  );
  kepo_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .go(sq_go), .x_i(sq_x),
    .done(sq_done), .root(sroot)
  );

  always_comb begin
    case (cmd.step)
      ST_H1:   hk_const = COS_C4;
      ST_H2:   hk_const = COS_C3;
      ST_H3:   hk_const = COS_C2;
      default: hk_const = COS_C1;
    endcase
  end

  assign c_raw   = 36'h0_4000_0000 - {2'b00, mprod[63:30]};
  assign den     = cneg_r ? 47'h4000_0000_0000 - mprod[46:0]
                          : 47'h4000_0000_0000 + mprod[46:0];
  assign m       = 33'((mprod + 64'h1000_0000) >> 29);

  assign qs      = fneg ? 58'd0 - {2'd0, quo[55:0]} : {2'd0, quo[55:0]};
  assign sum     = {{26{phase_r[31]}}, phase_r} + qs;
  assign sum_abs = sum[57] ? 58'd0 - sum : sum;
  assign frac    = {8'd0, sum_abs[23:0]};
  assign phase_nxt = sum[57] ? 32'd0 - frac : frac;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bf_r        <= 32'd0;
      be_r        <= 16'd0;
      fs_r        <= 19'd48000;
      rad_r       <= 1'b1;
      phase_r     <= 32'd0;
      prev_r      <= 32'd65536;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_BASE_FREQ: bf_r  <= cfg_wdata;
          CFG_BASE_ECC:  be_r  <= cfg_wdata[15:0];
          CFG_FS:        fs_r  <= cfg_wdata[18:0];
          CFG_RADIAN:    rad_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.take_in && in_tuser[2]) phase_r <= 32'd0;
      if (cmd.step == ST_RSQ && sq_done) prev_r <= {15'd0, sroot[24:8]};
      if (cmd.step == ST_Q && div_done) begin
        phase_r <= phase_nxt;
        prev_r  <= g_r;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      f_r <= in_tuser[0] ? in_tdata[31:0] : bf_r;
      e_r <= e_sel;
      a_r <= 33'h1_0000_0000 - (33'(e_sel) * 33'(e_sel));
    end
    if (cmd.step == ST_BSQ && sq_done) b_r <= sroot;
    if (cmd.step == ST_Z && mul_done) begin
      z_r <= mprod[48:18];
      p_r <= COS_C5;
    end
    if ((cmd.step == ST_H1 || cmd.step == ST_H2 || cmd.step == ST_H3 ||
         cmd.step == ST_H4) && mul_done) begin
      p_r <= hk_const - mprod[61:30];
    end
    if (cmd.step == ST_H5 && mul_done) begin
      cmag_r <= c_raw[35] ? 31'd0 : c_raw[30:0];
      cneg_r <= fold_neg;
    end
    if (cmd.step == ST_EC && mul_done) d7_r <= den[46:7];
    if (cmd.step == ST_L && div_done) begin
      l_r      <= quo[25:0];
      radius_r <= (quo[63:25] != 39'd0) ? 17'h1_FFFF : quo[24:8];
    end
    if (cmd.step == ST_T && div_done) t_r <= quo[41:0];
    if (cmd.step == ST_G && div_done) begin
      g_r <= (quo[63:32] != 32'd0) ? 32'hFFFF_FFFF : quo[31:0];
    end
    if (cmd.step == ST_RAD && mul_done) begin
      pout_r <= rad_r ? (phase_r[31] ? 32'd0 - m[31:0] : m[31:0]) - PI_Q24 : phase_r;
    end
    if (cmd.step == ST_S && mul_done) prod_r <= mprod;
    if (cmd.emit) begin
      out_radius_r <= radius_r;
      out_phase_r  <= pout_r;
    end
  end

  always_comb begin
    sts.unit_done = mul_done | div_done | sq_done;
    sts.restart   = in_tuser[2];
    sts.out_free  = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_phase_r, out_radius_r};
endmodule

@@ rtl/kepo_ctrl.sv @@
// Sequencer for one sample: steps the shared units through the orbit
// computation. Uses kepo_pkg.
`timescale 1ns / 1ps
module kepo_ctrl import kepo_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  kepo_sts_t sts,
  output kepo_cmd_t cmd
);
  kepo_state_t state_r, state_nxt;
  logic        issued_r, issued_nxt;
  logic        is_unit;

  assign is_unit = (state_r != ST_IDLE) && (state_r != ST_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    issued_nxt = is_unit && !sts.unit_done;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = sts.restart ? ST_RSQ : ST_BSQ;
      ST_RSQ:  if (sts.unit_done) state_nxt = ST_BSQ;
      ST_BSQ:  if (sts.unit_done) state_nxt = ST_Z;
      ST_Z:    if (sts.unit_done) state_nxt = ST_H1;
      ST_H1:   if (sts.unit_done) state_nxt = ST_H2;
      ST_H2:   if (sts.unit_done) state_nxt = ST_H3;
      ST_H3:   if (sts.unit_done) state_nxt = ST_H4;
      ST_H4:   if (sts.unit_done) state_nxt = ST_H5;
      ST_H5:   if (sts.unit_done) state_nxt = ST_EC;
      ST_EC:   if (sts.unit_done) state_nxt = ST_L;
      ST_L:    if (sts.unit_done) state_nxt = ST_T;
      ST_T:    if (sts.unit_done) state_nxt = ST_G;
      ST_G:    if (sts.unit_done) state_nxt = ST_RAD;
      ST_RAD:  if (sts.unit_done) state_nxt = ST_S;
      ST_S:    if (sts.unit_done) state_nxt = ST_Q;
      ST_Q:    if (sts.unit_done) state_nxt = ST_DONE;
      ST_DONE: if (sts.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.step    = state_r;
    cmd.go      = is_unit && !issued_r;
    cmd.take_in = (state_r == ST_IDLE) && in_tvalid;
    cmd.emit    = (state_r == ST_DONE) && sts.out_free;
    in_tready   = (state_r == ST_IDLE);
  end
endmodule

@@ rtl/kepler_orbit_oscillator.sv @@
// Top level of the Kepler orbit oscillator: sequencer plus datapath.
// Uses kepo_pkg, kepo_ctrl, kepo_dp.
// One sample at a time; the time from acceptance to out_tvalid is set by
// four divider steps (1 quotient bit per cycle), the square-root steps and
// nine multiply steps. The next sample is taken only after the result has
// moved to the output register, which waits while the output stalls.
// Synchronous active-low reset restores phase 0, rate 1.0, defaults.
`timescale 1ns / 1ps
module kepler_orbit_oscillator import kepo_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // sample_frequency, sample_eccentricity
  input  logic [2:0]  in_tuser,   // frequency_from_input, eccentricity_from_input, restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // radius, phase, zero fill
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);
  kepo_cmd_t cmd;
  kepo_sts_t sts;

  kepo_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .sts(sts), .cmd(cmd)
  );

  kepo_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tready(out_tready), .out_tvalid(out_tvalid), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );
endmodule

@@ rtl/kepo_checker.sv @@
// Port-level checks for the Kepler orbit oscillator, bound to the top level.
// Uses no package items.
`timescale 1ns / 1ps
module kepo_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output transaction dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && !$rose(out_tvalid))
    else $error("input taken again before the sample finished");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset left a result or a busy sequencer");

  a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[55:49] == 7'd0)
    else $error("output fill bits not zero");
endmodule

bind kepler_orbit_oscillator kepo_checker u_kepo_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

@@ tb/tb_kepler_orbit_oscillator.sv @@
// Testbench for kepler_orbit_oscillator: drives samples and register writes,
// predicts radius and phase per sample and compares them. Uses kepo_pkg.
`timescale 1ns / 1ps

class orbit_scoreboard;
  logic [31:0] base_freq;
  logic [15:0] base_ecc;
  logic [18:0] fs_hz;
  logic        radian;
  logic [31:0] orbit_phase;
  logic [31:0] prev_rate;
  logic [16:0] radius_q[$];
  logic [31:0] phase_q[$];
  int          errors;

  function new();
    base_freq = 0;
    base_ecc = 0;
    fs_hz = 19'd48000;
    radian = 1'b1;
    orbit_phase = 0;
    prev_rate = 32'd65536;
    errors = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      kepo_pkg::CFG_BASE_FREQ: base_freq = val;
      kepo_pkg::CFG_BASE_ECC:  base_ecc = val[15:0];
      kepo_pkg::CFG_FS:        fs_hz = val[18:0];
      kepo_pkg::CFG_RADIAN:    radian = val[0];
      default: ;
    endcase
  endfunction

  function logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > x) bits = bits >> 2;
    while (bits != 0) begin
      if (x >= res + bits) begin
        x = x - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  function logic [63:0] root_q24(logic [15:0] e);
    logic [63:0] a;
    a = (64'd1 << 32) - 64'(e) * 64'(e);
    return isqrt(a << 16);
  endfunction

  function longint cos_q30(logic [31:0] ph);
    longint x, h, u, z, p, c;
    bit neg;
    x = longint'(ph[23:0]);
    h = (x < (64'sd1 << 23)) ? x : 64'sd16777216 - x;
    if (h <= (64'sd1 << 22)) begin
      u = 4 * h;
      neg = 0;
    end else begin
      u = 4 * ((64'sd1 << 23) - h);
      neg = 1;
    end
    z = (u * u) >>> 18;
    p = longint'(kepo_pkg::COS_C5);
    p = longint'(kepo_pkg::COS_C4) - ((p * z) >>> 30);
    p = longint'(kepo_pkg::COS_C3) - ((p * z) >>> 30);
    p = longint'(kepo_pkg::COS_C2) - ((p * z) >>> 30);
    p = longint'(kepo_pkg::COS_C1) - ((p * z) >>> 30);
    c = 64'sd1073741824 - ((p * z) >>> 30);
    if (c < 0) c = 0;
    if (c > 64'sd1073741824) c = 64'sd1073741824;
    return neg ? -c : c;
  endfunction

  function void note_sample(logic [47:0] data, logic [2:0] flags);
    logic [31:0] f;
    logic [15:0] e;
    logic [63:0] a, b, l, den, rad, t, g, s, fmag, prod, fs, q, mag;
    longint c, r, sum, ph_out, m;
    bit fneg;
    f = flags[0] ? data[31:0] : base_freq;
    e = flags[1] ? data[47:32] : base_ecc;
    if (flags[2]) begin
      orbit_phase = 0;
      prev_rate = 32'(root_q24(base_ecc) >> 8);
    end
    a = (64'd1 << 32) - 64'(e) * 64'(e);
    b = root_q24(e);
    c = cos_q30(orbit_phase);
    if (c >= 0) den = (64'd1 << 46) + 64'(e) * 64'(c);
    else den = (64'd1 << 46) - 64'(e) * 64'(-c);
    l = (a << 31) / (den >> 7);
    rad = l >> 8;
    if (rad > 64'd131071) rad = 64'd131071;
    if (l == 0) begin
      g = 64'hFFFF_FFFF;
    end else begin
      t = (b << 24) / l;
      g = (t << 16) / l;
      if (g > 64'hFFFF_FFFF) g = 64'hFFFF_FFFF;
    end
    r = longint'($signed(orbit_phase));
    if (radian) begin
      mag = 64'(r < 0 ? -r : r);
      m = longint'((mag * 64'(kepo_pkg::TWO_PI_Q29) + (64'd1 << 28)) >> 29);
      ph_out = (r < 0 ? -m : m) - longint'(kepo_pkg::PI_Q24);
    end else begin
      ph_out = r;
    end
    s = g + 64'(prev_rate);
    fneg = f[31];
    fmag = fneg ? (64'd1 << 32) - 64'(f) : 64'(f);
    prod = s * fmag;
    fs = (fs_hz == 0) ? 64'd1 : 64'(fs_hz);
    q = prod / (fs << 9);
    sum = r + (fneg ? -longint'(q) : longint'(q));
    if (sum >= 0) r = sum & 64'hFFFFFF;
    else r = -((-sum) & 64'hFFFFFF);
    orbit_phase = 32'(r);
    prev_rate = 32'(g);
    radius_q.push_back(17'(rad));
    phase_q.push_back(32'(ph_out));
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %h expected %h", what, got, want);
  endtask

  task check_result(logic [55:0] data);
    logic [16:0] er;
    logic [31:0] ep;
    if (radius_q.size() == 0) begin
      report("unexpected transaction", 32'(data), 0);
      return;
    end
    er = radius_q.pop_front();
    ep = phase_q.pop_front();
    if (data[16:0] !== er) report("radius", 32'(data[16:0]), 32'(er));
    if (data[48:17] !== ep) report("phase", data[48:17], ep);
    if (data[55:49] !== 0) report("fill", 32'(data[55:49]), 0);
  endtask
endclass

module tb_kepler_orbit_oscillator;
  import kepo_pkg::*;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [47:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid, out_tready;
  logic [55:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_wdata;

  orbit_scoreboard sb;
  int  idle_cycles;
  bit  hold_off;
  bit  stall_mode;

  kepler_orbit_oscillator uut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (in_tvalid && in_tready) sb.note_sample(in_tdata, in_tuser);
    if (out_tvalid && out_tready) sb.check_result(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles > 20000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: own stall pattern, plus one long hold-off
  initial begin
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_off) out_tready <= 0;
      else if (stall_mode) out_tready <= ($urandom_range(0, 3) != 0);
      else out_tready <= 1;
    end
  end

  initial begin
    stall_mode = 0;
    forever begin
      repeat ($urandom_range(200, 3000)) @(negedge clk);
      stall_mode = ~stall_mode;
    end
  end

  task automatic send(logic [31:0] f, logic [15:0] e, logic [2:0] flags);
    in_tdata <= {e, f};
    in_tuser <= flags;
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_gap();
    in_tvalid <= 0;
    repeat ($urandom_range(1, 40)) @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.radius_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
  endtask

  task automatic random_burst(int n);
    int burst;
    logic [15:0] e;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && n > 0) begin
        case ($urandom_range(0, 3))
          0: e = 16'hFFFF - 16'($urandom_range(0, 255));
          1: e = 16'($urandom_range(0, 255));
          default: e = 16'($urandom);
        endcase
        send($urandom, e, {($urandom_range(0, 15) == 0), 2'($urandom)});
        burst--;
        n--;
      end
      pause_gap();
    end
  endtask

  initial begin
    sb = new();
    hold_off = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tuser = 0;
    cfg_we = 0;
    cfg_addr = CFG_BASE_FREQ;
    cfg_wdata = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: defaults, field extremes, flags, restart
    send(32'h0, 16'h0, 3'b000);
    send(32'h7FFF_FFFF, 16'hFFFF, 3'b011);
    send(32'h8000_0000, 16'hFFFF, 3'b011);
    send(32'hFFFF_FFFF, 16'h0001, 3'b011);
    send(32'h0100_0000, 16'h8000, 3'b111);
    send(32'h0001_0000, 16'hFFFF, 3'b010);
    send(32'hFF00_0000, 16'h0000, 3'b001);
    send(32'h8000_0000, 16'hC000, 3'b011);
    drain();
    write_cfg(CFG_BASE_FREQ, 32'h8000_0000);
    write_cfg(CFG_BASE_ECC, 32'h0000_FFFF);
    write_cfg(CFG_FS, 32'd1);
    write_cfg(CFG_RADIAN, 32'd0);
    send(32'h0, 16'h0, 3'b100);
    send(32'h0, 16'h0, 3'b000);
    send(32'h7FFF_FFFF, 16'h0, 3'b001);
    send(32'h0, 16'hFFFF, 3'b010);
    drain();
    write_cfg(CFG_FS, 32'd0);
    write_cfg(CFG_BASE_FREQ, 32'h7FFF_FFFF);
    send(32'h0, 16'h0, 3'b000);
    send(32'h0, 16'h0, 3'b100);
    drain();
    write_cfg(CFG_FS, 32'h7FFFF);
    write_cfg(CFG_RADIAN, 32'd1);
    send(32'h0, 16'h0, 3'b000);
    send(32'h1234_5678, 16'h7777, 3'b111);
    drain();

    // long receiver hold-off while the sender keeps offering
    write_cfg(CFG_FS, 32'd384000);
    write_cfg(CFG_BASE_ECC, 32'h0000_4000);
    hold_off = 1;
    fork
      random_burst(6);
      begin
        repeat (3000) @(negedge clk);
        hold_off = 0;
      end
    join
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_cfg(CFG_FS, 32'd48000); write_cfg(CFG_BASE_FREQ, 32'h01B8_0000); end
        1: begin write_cfg(CFG_FS, 32'd1); write_cfg(CFG_RADIAN, 32'd0); end
        2: begin write_cfg(CFG_FS, 32'd44100); write_cfg(CFG_BASE_ECC, 32'($urandom)); end
        3: begin write_cfg(CFG_FS, 32'd384000); write_cfg(CFG_RADIAN, 32'd1); end
        4: begin write_cfg(CFG_FS, 32'($urandom_range(1, 1000)));
                 write_cfg(CFG_BASE_FREQ, $urandom); end
        default: begin write_cfg(CFG_FS, 32'd0); write_cfg(CFG_BASE_ECC, 32'hFFFF); end
      endcase
      random_burst(155);
      drain();
    end

    in_tvalid <= 0;
    while (sb.radius_q.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
